[src/crp_pkg.sv]
// package with record ids, parse phases and limits of the capability record parser
package crp_pkg;

	// record ids, 16-bit little-endian on the wire
	localparam logic [15:0] ID_INDOOR_HUMIDITY = 16'h0015;
	localparam logic [15:0] ID_SILKY_COOL      = 16'h0018;
	localparam logic [15:0] ID_SMART_EYE       = 16'h0030;
	localparam logic [15:0] ID_WIND_ON_ME      = 16'h0032;
	localparam logic [15:0] ID_WIND_OF_ME      = 16'h0033;
	localparam logic [15:0] ID_ACTIVE_CLEAN    = 16'h0039;
	localparam logic [15:0] ID_ONE_KEY_NO_WIND = 16'h0042;
	localparam logic [15:0] ID_BREEZE_CONTROL  = 16'h0043;
	localparam logic [15:0] ID_FAN_SPEED       = 16'h0210;
	localparam logic [15:0] ID_ECO             = 16'h0212;
	localparam logic [15:0] ID_FROST_PROTECT   = 16'h0213;
	localparam logic [15:0] ID_MODES           = 16'h0214;
	localparam logic [15:0] ID_SWING           = 16'h0215;
	localparam logic [15:0] ID_POWER_CAL       = 16'h0216;
	localparam logic [15:0] ID_NEST            = 16'h0217;
	localparam logic [15:0] ID_AUX_HEAT        = 16'h0219;
	localparam logic [15:0] ID_TURBO           = 16'h021A;
	localparam logic [15:0] ID_HUMIDITY_SET    = 16'h021F;
	localparam logic [15:0] ID_UNIT_CHANGE     = 16'h0222;
	localparam logic [15:0] ID_LIGHT_CONTROL   = 16'h0224;
	localparam logic [15:0] ID_TEMPERATURES    = 16'h0225;
	localparam logic [15:0] ID_BUZZER          = 16'h022C;

	// record phase: 0..2 header bytes seen, then PHASE_DATA + data bytes stored
	localparam logic [3:0] PHASE_ID_LO  = 4'd0;
	localparam logic [3:0] PHASE_ID_HI  = 4'd1;
	localparam logic [3:0] PHASE_LENGTH = 4'd2;
	localparam logic [3:0] PHASE_DATA   = 4'd3;
	localparam logic [3:0] PHASE_FULL   = 4'd10;

	// data bytes kept per record and temperature record sizes
	localparam int DATA_DEPTH = 7;
	localparam logic [3:0] TEMP_MIN_GOT  = 4'd6;
	localparam logic [3:0] TEMP_LONG_GOT = 4'd7;

	// smallest frame (last byte included) whose updates are committed
	localparam int MIN_FRAME_BYTES = 14;

	// saturation of the byte count after parsing stopped
	localparam logic [8:0] AFTER_STOP_MAX = 9'd511;

	typedef logic [7:0] byte_t;
	typedef logic [29:0] flags_t;
	typedef logic [55:0] temps_t;

endpackage

[src/capability_record_parser_top.sv]
// top level of the capability record parser: byte parsing, record decode and commit
//
// One frame byte is taken per request, and a new byte can be taken in every cycle.
// A byte passes an input register and is parsed there against the frame state,
// and a frame's result (on its last byte) goes from the input register into an
// output register. The input side stalls only when a last byte waits in the
// input register while the previous result is still not taken, so the sustained
// rate is one byte per cycle as long as results are drained. Capability
// flags are bit 0 upward: indoor humidity, silky cool, smart eye, wind on me, wind of
// me, active clean, one key no wind on me, breeze control, fan speed control, eco,
// special eco, frost protection, cool, heat, dry, auto, updown fan, leftright fan,
// power cal, power cal setting, nest check, nest need change, electric aux heating,
// turbo cool, turbo heat, auto set humidity, manual set humidity, unit changeable,
// light control, buzzer. Temperature limits are raw half-degree bytes, bits 7:0
// upward: cool min/max, auto min/max, heat min/max.
module capability_record_parser_top #(
	parameter int MAX_FRAME_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_accepted,
	output logic        need_more,
	output logic [29:0] capability_flags,
	output logic [47:0] temperature_limits,
	output logic [7:0]  decimals_setting
);

	localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [PW-1:0] POS_LIMIT  = PW'(MAX_FRAME_BYTES - 1);
	localparam logic [PW-1:0] POS_MAX    = PW'(MAX_FRAME_BYTES);
	localparam logic [PW-1:0] POS_COUNT  = PW'(1);
	localparam logic [PW-1:0] POS_RECORD = PW'(2);
	localparam logic [PW-1:0] POS_ACCEPT = PW'(crp_pkg::MIN_FRAME_BYTES - 1);

	// input register
	logic          valid_s1;
	crp_pkg::byte_t byte_s1;
	logic          last_s1;
	logic          go;

	// frame state
	logic [PW-1:0]   pos_q;
	logic [7:0]      left_q;
	logic [3:0]      phase_q;
	logic [15:0]     id_q;
	logic [7:0]      len_q;
	crp_pkg::byte_t  data_q [crp_pkg::DATA_DEPTH];
	logic            stopped_q;
	logic [8:0]      after_q;
	crp_pkg::byte_t  first_q;
	crp_pkg::flags_t wflags_q;
	crp_pkg::flags_t cflags_q;
	crp_pkg::temps_t wtemps_q;
	crp_pkg::temps_t ctemps_q;

	// next values
	logic [PW-1:0]   pos_n;
	logic [7:0]      left_n;
	logic [3:0]      phase_n;
	logic [15:0]     id_n;
	logic [7:0]      len_n;
	logic            stopped_n;
	logic [8:0]      after_n;
	crp_pkg::byte_t  first_n;
	crp_pkg::flags_t wflags_n;
	crp_pkg::flags_t cflags_n;
	crp_pkg::temps_t wtemps_n;
	crp_pkg::temps_t ctemps_n;
	logic            wr_en;
	logic [2:0]      wr_idx;

	// record decode inputs and outputs
	crp_pkg::byte_t  view [crp_pkg::DATA_DEPTH];
	logic [3:0]      phase_after;
	logic [3:0]      got;
	logic [7:0]      len_dec;
	crp_pkg::flags_t dec_flags;
	crp_pkg::temps_t dec_temps;

	// frame end status
	logic            accepted;
	logic [8:0]      avail;
	crp_pkg::byte_t  first_sel;

	// output register
	logic            out_valid_q;
	logic            accepted_q;
	logic            more_q;
	crp_pkg::flags_t oflags_q;
	crp_pkg::temps_t otemps_q;

	// handshake: a last byte waits while the previous result is held
	assign go       = valid_s1 && !(last_s1 && out_valid_q && !out_ready);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= frame_byte;
			last_s1 <= last_byte;
		end
	end

	// data bytes as seen after this byte is stored
	assign wr_idx      = 3'(phase_q - crp_pkg::PHASE_DATA);
	assign phase_after = (phase_q < crp_pkg::PHASE_FULL) ? phase_q + 4'd1 : phase_q;
	assign got         = phase_after - crp_pkg::PHASE_DATA;
	assign len_dec     = len_q - 8'd1;

	always_comb begin
		for (int i = 0; i < crp_pkg::DATA_DEPTH; i++) begin
			view[i] = (wr_en && wr_idx == 3'(i)) ? byte_s1 : data_q[i];
		end
	end

	// record decode by id on the first data byte, temperatures on all stored data bytes
	always_comb begin
		crp_pkg::byte_t u;
		u         = view[0];
		dec_flags = wflags_q;
		dec_temps = wtemps_q;
		case (id_q)
			crp_pkg::ID_INDOOR_HUMIDITY: dec_flags[0] = (u != 8'd0);
			crp_pkg::ID_SILKY_COOL:      dec_flags[1] = (u != 8'd0);
			crp_pkg::ID_SMART_EYE:       dec_flags[2] = (u == 8'd1);
			crp_pkg::ID_WIND_ON_ME:      dec_flags[3] = (u == 8'd1);
			crp_pkg::ID_WIND_OF_ME:      dec_flags[4] = (u == 8'd1);
			crp_pkg::ID_ACTIVE_CLEAN:    dec_flags[5] = (u == 8'd1);
			crp_pkg::ID_ONE_KEY_NO_WIND: dec_flags[6] = (u == 8'd1);
			crp_pkg::ID_BREEZE_CONTROL:  dec_flags[7] = (u == 8'd1);
			crp_pkg::ID_FAN_SPEED:       dec_flags[8] = (u != 8'd1);
			crp_pkg::ID_ECO: begin
				dec_flags[9]  = (u == 8'd1);
				dec_flags[10] = (u == 8'd2);
			end
			crp_pkg::ID_FROST_PROTECT:   dec_flags[11] = (u == 8'd1);
			// cool, heat, dry, auto
			crp_pkg::ID_MODES: begin
				case (u)
					8'd0: dec_flags[15:12] = 4'b1101;
					8'd1: dec_flags[15:12] = 4'b1111;
					8'd2: dec_flags[15:12] = 4'b1010;
					8'd3: dec_flags[15:12] = 4'b0001;
					default: ;
				endcase
			end
			// updown, leftright
			crp_pkg::ID_SWING: begin
				if (u inside {[8'd0:8'd3]}) begin
					dec_flags[16] = !u[1];
					dec_flags[17] = u[0];
				end
			end
			crp_pkg::ID_POWER_CAL: begin
				if (u inside {[8'd0:8'd1]}) begin
					dec_flags[19:18] = 2'b00;
				end else if (u == 8'd2) begin
					dec_flags[19:18] = 2'b01;
				end else if (u == 8'd3) begin
					dec_flags[19:18] = 2'b11;
				end
			end
			crp_pkg::ID_NEST: begin
				case (u)
					8'd0:       dec_flags[21:20] = 2'b00;
					8'd1, 8'd2: dec_flags[21:20] = 2'b01;
					8'd3:       dec_flags[21:20] = 2'b10;
					8'd4:       dec_flags[21:20] = 2'b11;
					default: ;
				endcase
			end
			crp_pkg::ID_AUX_HEAT: dec_flags[22] = (u != 8'd0);
			// turbo cool, turbo heat
			crp_pkg::ID_TURBO: begin
				if (u inside {[8'd0:8'd3]}) begin
					dec_flags[23] = !u[1];
					dec_flags[24] = u[0];
				end
			end
			// auto set, manual set humidity
			crp_pkg::ID_HUMIDITY_SET: begin
				if (u inside {[8'd0:8'd3]}) begin
					dec_flags[25] = (u == 8'd1) || (u == 8'd2);
					dec_flags[26] = u[1];
				end
			end
			crp_pkg::ID_UNIT_CHANGE:   dec_flags[27] = (u == 8'd0);
			crp_pkg::ID_LIGHT_CONTROL: dec_flags[28] = (u != 8'd0);
			// six limits, decimals from byte 6 or byte 2 of a short record
			crp_pkg::ID_TEMPERATURES: begin
				if (got >= crp_pkg::TEMP_MIN_GOT) begin
					dec_temps = {(got >= crp_pkg::TEMP_LONG_GOT) ? view[6] : view[2],
						view[5], view[4], view[3], view[2], view[1], view[0]};
				end
			end
			crp_pkg::ID_BUZZER: dec_flags[29] = (u != 8'd0);
			default: ;
		endcase
	end

	// frame end status
	assign accepted = (pos_q >= POS_ACCEPT);

	always_comb begin
		if (stopped_q) begin
			avail     = after_q;
			first_sel = first_q;
		end else if (pos_q >= POS_RECORD && phase_q < crp_pkg::PHASE_DATA) begin
			avail     = {5'd0, phase_q};
			first_sel = id_q[7:0];
		end else begin
			avail     = 9'd0;
			first_sel = 8'd0;
		end
	end

	// per byte parse step
	always_comb begin
		pos_n     = pos_q;
		left_n    = left_q;
		phase_n   = phase_q;
		id_n      = id_q;
		len_n     = len_q;
		stopped_n = stopped_q;
		after_n   = after_q;
		first_n   = first_q;
		wflags_n  = wflags_q;
		wtemps_n  = wtemps_q;
		cflags_n  = cflags_q;
		ctemps_n  = ctemps_q;
		wr_en     = 1'b0;
		if (last_s1) begin
			// commit when long enough, then start a new frame
			if (accepted) begin
				cflags_n = wflags_q;
				ctemps_n = wtemps_q;
			end
			wflags_n  = cflags_n;
			wtemps_n  = ctemps_n;
			pos_n     = '0;
			left_n    = 8'd0;
			phase_n   = crp_pkg::PHASE_ID_LO;
			id_n      = 16'd0;
			len_n     = 8'd0;
			stopped_n = 1'b0;
			after_n   = 9'd0;
			first_n   = 8'd0;
		end else begin
			if (pos_q < POS_LIMIT) begin
				if (pos_q == POS_COUNT) begin
					left_n = byte_s1;
				end else if (pos_q >= POS_RECORD) begin
					if (stopped_q) begin
						// bytes after stop only counted
						if (after_q == 9'd0) begin
							first_n = byte_s1;
						end
						if (after_q < crp_pkg::AFTER_STOP_MAX) begin
							after_n = after_q + 9'd1;
						end
					end else if (phase_q == crp_pkg::PHASE_ID_LO && left_q == 8'd0) begin
						stopped_n = 1'b1;
						after_n   = 9'd1;
						first_n   = byte_s1;
					end else if (phase_q == crp_pkg::PHASE_ID_LO) begin
						id_n    = {8'd0, byte_s1};
						phase_n = crp_pkg::PHASE_ID_HI;
					end else if (phase_q == crp_pkg::PHASE_ID_HI) begin
						id_n    = {byte_s1, id_q[7:0]};
						phase_n = crp_pkg::PHASE_LENGTH;
					end else if (phase_q == crp_pkg::PHASE_LENGTH) begin
						len_n = byte_s1;
						if (byte_s1 == 8'd0) begin
							// empty record counts, changes nothing
							left_n  = left_q - 8'd1;
							phase_n = crp_pkg::PHASE_ID_LO;
						end else begin
							phase_n = crp_pkg::PHASE_DATA;
						end
					end else begin
						wr_en   = (phase_q < crp_pkg::PHASE_FULL);
						phase_n = phase_after;
						len_n   = len_dec;
						if (len_dec == 8'd0) begin
							wflags_n = dec_flags;
							wtemps_n = dec_temps;
							left_n   = left_q - 8'd1;
							phase_n  = crp_pkg::PHASE_ID_LO;
						end
					end
				end
			end
			if (pos_q < POS_MAX) begin
				pos_n = pos_q + POS_COUNT;
			end
		end
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			left_q    <= 8'd0;
			phase_q   <= crp_pkg::PHASE_ID_LO;
			id_q      <= 16'd0;
			len_q     <= 8'd0;
			stopped_q <= 1'b0;
			after_q   <= 9'd0;
			first_q   <= 8'd0;
			wflags_q  <= '0;
			cflags_q  <= '0;
			wtemps_q  <= '0;
			ctemps_q  <= '0;
		end else if (go) begin
			pos_q     <= pos_n;
			left_q    <= left_n;
			phase_q   <= phase_n;
			id_q      <= id_n;
			len_q     <= len_n;
			stopped_q <= stopped_n;
			after_q   <= after_n;
			first_q   <= first_n;
			wflags_q  <= wflags_n;
			cflags_q  <= cflags_n;
			wtemps_q  <= wtemps_n;
			ctemps_q  <= ctemps_n;
		end
	end

	// record data bytes
	always_ff @(posedge clk) begin
		if (go && !last_s1 && wr_en) begin
			data_q[wr_idx] <= byte_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			accepted_q <= accepted;
			more_q     <= accepted && avail == 9'd2 && first_sel != 8'd0;
			oflags_q   <= cflags_n;
			otemps_q   <= ctemps_n;
		end
	end

	assign out_valid          = out_valid_q;
	assign frame_accepted     = accepted_q;
	assign need_more          = more_q;
	assign capability_flags   = oflags_q;
	assign temperature_limits = otemps_q[47:0];
	assign decimals_setting   = otemps_q[55:48];

endmodule
